[src/pds_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pds_pkg
// Shared types, constants and the hex digit decoder for the percent decoder.
// ----------------------------------------------------------------------------
package pds_pkg;

	localparam logic [7:0] PCT_CHAR = 8'h25;

	// bundles held between front and back
	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);
	localparam int QCW    = $clog2(QDEPTH + 1);

	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_last;
	} pds_in_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_last;
	} pds_out_t;

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_PCT   = 2'd1,
		PH_DIGIT = 2'd2
	} pds_phase_t;

	// all bytes caused by one input transaction; last applies to the final byte
	typedef struct packed {
		logic [2:0][7:0] data;
		logic [1:0]      cnt;
		logic            last;
	} pds_bundle_t;

	typedef struct packed {
		logic ok;
		logic [3:0] val;
	} pds_hex_t;

	function automatic pds_hex_t hex_decode(input logic [7:0] c);
		pds_hex_t h;
		h.ok  = 1'b1;
		h.val = 4'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			h.val = c[3:0];
		end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
			h.val = c[3:0] + 4'd9;
		end else begin
			h.ok = 1'b0;
		end
		return h;
	endfunction

endpackage

[src/pds_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pds_front
// Accepts raw bytes, tracks the escape phase and builds at most one output
// bundle per input transaction.
// ----------------------------------------------------------------------------
module pds_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 raw_valid,
	output logic                 raw_stall,
	input  pds_pkg::pds_in_t     raw_data,
	input  logic                 q_full,
	output logic                 push,
	output pds_pkg::pds_bundle_t push_data
);
	import pds_pkg::*;

	pds_phase_t phase_q, phase_nxt;
	logic [7:0] held_q;
	pds_hex_t   hx;
	pds_hex_t   hx_held;
	logic       accept;
	logic       fresh_hold;
	logic [7:0] b;

	assign b          = raw_data.in_byte;
	assign hx         = hex_decode(b);
	assign hx_held    = hex_decode(held_q);
	assign fresh_hold = (b == PCT_CHAR) && !raw_data.in_last;
	assign raw_stall  = q_full;
	assign accept     = raw_valid && !q_full;
	assign push       = accept && (push_data.cnt != 2'd0);

	always_comb begin
		phase_nxt = PH_IDLE;
		unique case (phase_q)
			PH_PCT: begin
				if (hx.ok) begin
					phase_nxt = raw_data.in_last ? PH_IDLE : PH_DIGIT;
				end else begin
					phase_nxt = fresh_hold ? PH_PCT : PH_IDLE;
				end
			end
			PH_DIGIT: begin
				if (hx.ok) begin
					phase_nxt = PH_IDLE;
				end else begin
					phase_nxt = fresh_hold ? PH_PCT : PH_IDLE;
				end
			end
			default: begin
				phase_nxt = fresh_hold ? PH_PCT : PH_IDLE;
			end
		endcase
	end

	always_comb begin
		push_data      = '0;
		push_data.last = raw_data.in_last;
		unique case (phase_q)
			PH_PCT: begin
				push_data.data[0] = PCT_CHAR;
				if (hx.ok) begin
					// digit at end of string: flush both literally
					push_data.data[1] = b;
					push_data.cnt     = raw_data.in_last ? 2'd2 : 2'd0;
				end else if (fresh_hold) begin
					push_data.cnt = 2'd1;
				end else begin
					push_data.data[1] = b;
					push_data.cnt     = 2'd2;
				end
			end
			PH_DIGIT: begin
				if (hx.ok) begin
					push_data.data[0] = {hx_held.val, hx.val};
					push_data.cnt     = 2'd1;
				end else begin
					push_data.data[0] = PCT_CHAR;
					push_data.data[1] = held_q;
					push_data.data[2] = b;
					push_data.cnt     = fresh_hold ? 2'd2 : 2'd3;
				end
			end
			default: begin
				push_data.data[0] = b;
				push_data.cnt     = fresh_hold ? 2'd0 : 2'd1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
		end else if (accept) begin
			phase_q <= phase_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && phase_q == PH_PCT && hx.ok && !raw_data.in_last) begin
			held_q <= b;
		end
	end

endmodule

[src/pds_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pds_queue
// Short FIFO of output bundles between the front and the back.
// ----------------------------------------------------------------------------
module pds_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  pds_pkg::pds_bundle_t push_data,
	output logic                 full,
	input  logic                 pop,
	output logic                 nempty,
	output pds_pkg::pds_bundle_t pop_data
);
	import pds_pkg::*;

	pds_bundle_t    mem_q [QDEPTH];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QCW-1:0] count_q;

	assign full     = (count_q == QCW'(QDEPTH));
	assign nempty   = (count_q != '0);
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QAW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QAW'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + QCW'(1);
				2'b01:   count_q <= count_q - QCW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[src/pds_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pds_back
// Unpacks bundles into single output bytes from a holding register.
// ----------------------------------------------------------------------------
module pds_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_nempty,
	input  pds_pkg::pds_bundle_t q_data,
	output logic                 pop,
	output logic                 dec_valid,
	input  logic                 dec_stall,
	output pds_pkg::pds_out_t    dec_data
);
	import pds_pkg::*;

	pds_bundle_t cur_q;
	logic        valid_q;
	logic [1:0]  idx_q;
	logic [1:0]  last_idx;
	logic        take;
	logic        done;

	assign last_idx  = cur_q.cnt - 2'd1;
	assign take      = valid_q && !dec_stall;
	assign done      = take && (idx_q == last_idx);
	assign pop       = q_nempty && (!valid_q || done);
	assign dec_valid = valid_q;

	assign dec_data.out_byte = cur_q.data[idx_q];
	assign dec_data.out_last = cur_q.last && (idx_q == last_idx);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= 2'd0;
		end else if (pop) begin
			valid_q <= 1'b1;
			idx_q   <= 2'd0;
		end else if (done) begin
			valid_q <= 1'b0;
		end else if (take) begin
			idx_q <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= q_data;
		end
	end

endmodule

[src/percent_decoder_stream.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// percent_decoder_stream
// Streaming URI percent-escape decoder, top level.
// ----------------------------------------------------------------------------
// Raw bytes enter on raw_valid/raw_stall/raw_data, with in_last on the final
// byte of a string. Decoded bytes leave on dec_valid/dec_stall/dec_data, with
// out_last on the final decoded byte. A "%XX" escape (hex digits, either case)
// becomes one byte; broken escapes are passed through literally, and anything
// held at the end of a string is flushed.
// One raw byte is accepted per cycle while the queue is not full. A transaction
// yields zero to three output bytes; the output side delivers one byte per
// cycle while dec_stall is low. The front logic and the output unpacker are
// separated by a 4-entry bundle queue, which sets how long the input keeps
// flowing while output is stalled.
// An accepted byte passes the bundle queue, then the output holding register.
// raw_stall rises only when the queue is full, i.e. after a stall on the
// output side has backed the queue up. Reset clears the escape state, the
// queue and the output register; no transaction is pending afterwards.
// ----------------------------------------------------------------------------
module percent_decoder_stream (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              raw_valid,
	output logic              raw_stall,
	input  pds_pkg::pds_in_t  raw_data,
	output logic              dec_valid,
	input  logic              dec_stall,
	output pds_pkg::pds_out_t dec_data
);
	import pds_pkg::*;

	logic        q_full;
	logic        q_push;
	logic        q_pop;
	logic        q_nempty;
	pds_bundle_t q_wdata;
	pds_bundle_t q_rdata;

	pds_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.raw_valid (raw_valid),
		.raw_stall (raw_stall),
		.raw_data  (raw_data),
		.q_full    (q_full),
		.push      (q_push),
		.push_data (q_wdata)
	);

	pds_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_wdata),
		.full      (q_full),
		.pop       (q_pop),
		.nempty    (q_nempty),
		.pop_data  (q_rdata)
	);

	pds_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_nempty  (q_nempty),
		.q_data    (q_rdata),
		.pop       (q_pop),
		.dec_valid (dec_valid),
		.dec_stall (dec_stall),
		.dec_data  (dec_data)
	);

endmodule

[src/pds_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pds_checker
// Port-level checks on the percent decoder, bound to the top level.
// ----------------------------------------------------------------------------
module pds_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              raw_valid,
	input logic              raw_stall,
	input pds_pkg::pds_in_t  raw_data,
	input logic              dec_valid,
	input logic              dec_stall,
	input pds_pkg::pds_out_t dec_data
);
	import pds_pkg::*;

	// output transaction held while stalled
	a_dec_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		dec_valid && dec_stall |=> dec_valid)
		else $error("dec_valid dropped while stalled");

	a_dec_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		dec_valid && dec_stall |=> $stable(dec_data))
		else $error("dec_data changed while stalled");

	// end of string always produces output
	a_last_emits: assert property (@(posedge clk) disable iff (!arst_n)
		raw_valid && !raw_stall && raw_data.in_last |-> ##2 dec_valid)
		else $error("no output after end of string");

	// queue can only back up behind a pending output byte
	a_no_idle_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!dec_valid |-> !raw_stall)
		else $error("input stalled with output idle");

endmodule

bind percent_decoder_stream pds_checker u_pds_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.raw_valid (raw_valid),
	.raw_stall (raw_stall),
	.raw_data  (raw_data),
	.dec_valid (dec_valid),
	.dec_stall (dec_stall),
	.dec_data  (dec_data)
);

[tb/percent_decoder_stream_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// percent_decoder_stream_tb
// Self-checking testbench for the streaming percent-escape decoder.
// ----------------------------------------------------------------------------
// A scoreboard class tracks the escape state on every accepted raw byte and
// queues the decoded bytes that should follow; each decoded transaction is
// compared against the oldest entry. Stimulus is a directed set of escapes,
// broken escapes and end-of-string cuts, followed by random strings that are
// mostly well-formed escapes plus raw noise. Both sides idle at random, the
// output side holds off long enough to back up the input, and the input side
// pauses once until the output has drained.
// ----------------------------------------------------------------------------
module percent_decoder_stream_tb;
	import pds_pkg::*;

	class percent_scoreboard;
		pds_phase_t phase;
		logic [7:0] held_digit;
		pds_out_t   decoded_due[$];
		int         mismatches;
		int         raw_seen;
		int         decoded_seen;

		function new();
			phase        = PH_IDLE;
			held_digit   = 8'h00;
			mismatches   = 0;
			raw_seen     = 0;
			decoded_seen = 0;
		endfunction

		function bit hex_nibble(input logic [7:0] c, output logic [3:0] v);
			logic [7:0] t;
			v = 4'd0;
			if (c >= 8'h30 && c <= 8'h39) begin
				v = c[3:0];
				return 1'b1;
			end
			if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
				t = (c >= 8'h61) ? c - 8'h57 : c - 8'h37;
				v = t[3:0];
				return 1'b1;
			end
			return 1'b0;
		endfunction

		function void push_decoded(input logic [7:0] b, input logic l);
			pds_out_t o;
			o.out_byte = b;
			o.out_last = l;
			decoded_due.push_back(o);
		endfunction

		// advance the escape state by one accepted raw transaction
		function void note_raw(input pds_in_t t);
			logic [3:0] lo;
			logic [3:0] hi;
			bit         is_hex;
			bit         fresh;
			raw_seen++;
			is_hex = hex_nibble(t.in_byte, lo);
			fresh  = 1'b1;
			case (phase)
				PH_PCT: begin
					if (is_hex) begin
						if (t.in_last) begin
							push_decoded(PCT_CHAR, 1'b0);
							push_decoded(t.in_byte, 1'b1);
							phase = PH_IDLE;
						end else begin
							held_digit = t.in_byte;
							phase      = PH_DIGIT;
						end
						fresh = 1'b0;
					end else begin
						push_decoded(PCT_CHAR, 1'b0);
						phase = PH_IDLE;
					end
				end
				PH_DIGIT: begin
					if (is_hex) begin
						void'(hex_nibble(held_digit, hi));
						push_decoded({hi, lo}, t.in_last);
						fresh = 1'b0;
					end else begin
						push_decoded(PCT_CHAR, 1'b0);
						push_decoded(held_digit, 1'b0);
					end
					phase      = PH_IDLE;
					held_digit = 8'h00;
				end
				default: phase = PH_IDLE;
			endcase
			// breaking byte is looked at as if nothing were held
			if (fresh) begin
				if (t.in_byte == PCT_CHAR && !t.in_last)
					phase = PH_PCT;
				else
					push_decoded(t.in_byte, t.in_last);
			end
		endfunction

		function void check_decoded(input pds_out_t got);
			pds_out_t want;
			decoded_seen++;
			if (decoded_due.size() == 0) begin
				$error("unexpected decoded transaction: out_byte 0x%02h out_last %0b",
					got.out_byte, got.out_last);
				mismatches++;
				return;
			end
			want = decoded_due.pop_front();
			if (got.out_byte !== want.out_byte) begin
				$error("out_byte: expected 0x%02h, got 0x%02h", want.out_byte, got.out_byte);
				mismatches++;
			end
			if (got.out_last !== want.out_last) begin
				$error("out_last: expected %0b, got %0b", want.out_last, got.out_last);
				mismatches++;
			end
		endfunction

		function int pending();
			return decoded_due.size();
		endfunction
	endclass

	logic     clk       = 1'b0;
	logic     arst_n    = 1'b0;
	logic     raw_valid = 1'b0;
	logic     raw_stall;
	pds_in_t  raw_data  = '0;
	logic     dec_valid;
	logic     dec_stall = 1'b0;
	pds_out_t dec_data;

	percent_scoreboard sb = new();

	bit src_idle      = 1'b0;
	bit sink_idle     = 1'b0;
	bit hold_trigger  = 1'b0;
	int hold_left     = 0;
	int input_stalls  = 0;
	bit hold_done     = 1'b0;
	bit drain_done    = 1'b0;

	percent_decoder_stream dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.raw_valid (raw_valid),
		.raw_stall (raw_stall),
		.raw_data  (raw_data),
		.dec_valid (dec_valid),
		.dec_stall (dec_stall),
		.dec_data  (dec_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	initial begin
		#400000;
		$display("** percent_decoder_stream: FAILED **");
		$finish;
	end

	// output side: check at the edge, then choose next cycle's stall
	initial begin
		forever begin
			@(posedge clk);
			if (arst_n && dec_valid && !dec_stall)
				sb.check_decoded(dec_data);
			if (hold_trigger) begin
				hold_left    = 60;
				hold_trigger = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				dec_stall <= 1'b1;
			end else begin
				dec_stall <= sink_idle && ($urandom_range(99) < 23);
			end
		end
	end

	task automatic send_raw(input pds_in_t t);
		while (src_idle && $urandom_range(99) < 23) begin
			raw_valid <= 1'b0;
			@(posedge clk);
		end
		raw_valid <= 1'b1;
		raw_data  <= t;
		@(posedge clk);
		while (raw_stall) begin
			input_stalls++;
			@(posedge clk);
		end
		sb.note_raw(t);
	endtask

	task automatic send_text(input string s, input bit mark_end);
		pds_in_t t;
		for (int i = 0; i < s.len(); i++) begin
			t.in_byte = s[i];
			t.in_last = mark_end && (i == s.len() - 1);
			send_raw(t);
		end
	endtask

	function automatic logic [7:0] rand_hex_char();
		case ($urandom_range(2))
			0:       return 8'h30 + 8'($urandom_range(9));
			1:       return 8'h41 + 8'($urandom_range(5));
			default: return 8'h61 + 8'($urandom_range(5));
		endcase
	endfunction

	// mostly valid escapes, with partial escapes, near-miss digits and raw bytes
	task automatic send_random_string();
		logic [7:0] seq[$];
		logic [7:0] near_miss[6] = '{8'h2F, 8'h3A, 8'h40, 8'h47, 8'h60, 8'h67};
		pds_in_t    t;
		int         len;
		int         pick;
		len = $urandom_range(1, 10);
		while (seq.size() < len) begin
			pick = $urandom_range(99);
			if (pick < 40) begin
				seq.push_back(PCT_CHAR);
				seq.push_back(rand_hex_char());
				seq.push_back(rand_hex_char());
			end else if (pick < 55) begin
				seq.push_back(PCT_CHAR);
				if ($urandom_range(1))
					seq.push_back(rand_hex_char());
			end else if (pick < 70) begin
				seq.push_back(near_miss[$urandom_range(5)]);
			end else begin
				seq.push_back(8'($urandom_range(255)));
			end
		end
		foreach (seq[i]) begin
			t.in_byte = seq[i];
			t.in_last = (i == seq.size() - 1);
			send_raw(t);
		end
	endtask

	initial begin
		pds_in_t t;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: escapes in both cases, extremes, broken and cut escapes
		send_text("%41", 1'b0);
		send_text("%fA", 1'b0);
		t.in_byte = 8'h00; t.in_last = 1'b0;
		send_raw(t);
		t.in_byte = 8'hFF; t.in_last = 1'b1;
		send_raw(t);
		send_text("%%3G", 1'b0);
		send_text("%4x", 1'b1);
		send_text("%z", 1'b0);
		send_text("%", 1'b1);
		send_text("%9", 1'b1);
		send_text("%c0", 1'b1);
		send_text("Q", 1'b1);

		src_idle  = 1'b1;
		sink_idle = 1'b1;
		while (sb.raw_seen < 200) begin
			if (!hold_done && sb.raw_seen >= 70) begin
				hold_trigger = 1'b1;
				hold_done    = 1'b1;
			end
			if (!drain_done && sb.raw_seen >= 120) begin
				raw_valid <= 1'b0;
				@(posedge clk);
				while (sb.pending() != 0)
					@(posedge clk);
				drain_done = 1'b1;
			end
			// stretch with no idling on either side
			src_idle  = !(sb.raw_seen >= 130 && sb.raw_seen < 180);
			sink_idle = src_idle;
			if ($urandom_range(99) < 15) begin
				t.in_byte = 8'($urandom_range(255));
				t.in_last = ($urandom_range(9) == 0);
				send_raw(t);
			end else begin
				send_random_string();
			end
		end
		raw_valid <= 1'b0;

		while (sb.pending() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("Sent %0d raw bytes, checked %0d decoded bytes; input stalled %0d cycles.",
			sb.raw_seen, sb.decoded_seen, input_stalls);
		$display("Covered valid, broken and end-cut escapes under random and long stalls.");
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("** percent_decoder_stream: PASSED **");
		else
			$display("** percent_decoder_stream: FAILED **");
		$finish;
	end

endmodule
